// File: rtl/cshr_pkg.sv
// ----------------------------------------------------------------------------
// cshr_pkg
// Types and constants shared by the cursor screen hit router.
// ----------------------------------------------------------------------------
package cshr_pkg;

    localparam int unsigned RECT_W = 15;
    localparam int unsigned POS_W  = 16;
    localparam int unsigned GPOS_W = 18;
    localparam int unsigned CFG_W  = 5;
    localparam int unsigned SCR_W  = 4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_ROUTE = 1'b1;

    typedef struct packed {
        logic [RECT_W-1:0] ox;
        logic [RECT_W-1:0] oy;
        logic [RECT_W-1:0] w;
        logic [RECT_W-1:0] h;
    } rect_t;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] rel_x;
        logic [POS_W-1:0] rel_y;
    } hit_t;

endpackage

// File: rtl/cursor_screen_hit_router.sv
// ----------------------------------------------------------------------------
// cursor_screen_hit_router
// Routes a cursor position across a table of screen rectangles.
// ----------------------------------------------------------------------------
// Write item: taken while idle, no result.
// Query: goes from idle straight to emit on the shortcut, emits after the local test
// when the point stays on its screen, else scans up to N = min(screens_in_use, MAX_SCREENS)
// entries, one table entry per cycle through the single read port and compare unit.
// Next item is taken the cycle after the result enters the output register.
// rst_n clears control and sets screens_in_use to 1; the table is not cleared.
module cursor_screen_hit_router
    import cshr_pkg::*;
#(
    parameter int unsigned MAX_SCREENS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_W-1:0]        cfg_data,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    op,
    input  logic [SCR_W-1:0]        entry_index,
    input  logic [RECT_W-1:0]       origin_x,
    input  logic [RECT_W-1:0]       origin_y,
    input  logic [RECT_W-1:0]       rect_width,
    input  logic [RECT_W-1:0]       rect_height,
    input  logic [SCR_W-1:0]        current_screen,
    input  logic signed [POS_W-1:0] local_x,
    input  logic signed [POS_W-1:0] local_y,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    switched,
    output logic [SCR_W-1:0]        new_screen,
    output logic signed [POS_W-1:0] out_x,
    output logic signed [POS_W-1:0] out_y
);

    localparam int unsigned AW = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1;
    localparam int unsigned CW = $clog2(MAX_SCREENS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CUR  = 4'b0010,
        S_SCAN = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    siu_reg;
    logic [CW-1:0]       scan_idx_reg, scan_idx_next;
    logic [SCR_W-1:0]    cur_reg;
    logic [POS_W-1:0]    lx_reg, ly_reg;
    logic [GPOS_W-1:0]   gx_reg, gx_next;
    logic [GPOS_W-1:0]   gy_reg, gy_next;
    logic                res_sw_reg, res_sw_next;
    logic [SCR_W-1:0]    res_scr_reg, res_scr_next;
    logic [POS_W-1:0]    res_x_reg, res_x_next;
    logic [POS_W-1:0]    res_y_reg, res_y_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_sw_reg;
    logic [SCR_W-1:0]    out_scr_reg;
    logic [POS_W-1:0]    out_x_reg, out_y_reg;

    rect_t               mem [MAX_SCREENS];
    rect_t               rd_data_reg;
    rect_t               wr_rect;
    rect_t               unit_rect;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;

    logic [CW-1:0]       n_lim;
    logic                in_take;
    logic                out_free;
    logic                shortcut;
    logic signed [GPOS_W-1:0] unit_x, unit_y;
    logic signed [GPOS_W-1:0] lx_ext, ly_ext;
    hit_t                unit_res;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign switched   = out_sw_reg;
    assign new_screen = out_scr_reg;
    assign out_x      = $signed(out_x_reg);
    assign out_y      = $signed(out_y_reg);

    always_comb
    begin
        if (32'(siu_reg) > MAX_SCREENS)
        begin
            n_lim = CW'(MAX_SCREENS);
        end
        else
        begin
            n_lim = CW'(siu_reg);
        end
    end

    assign shortcut = (siu_reg <= CFG_W'(1)) || (32'(current_screen) >= MAX_SCREENS);

    // table write and registered read
    assign wr_en      = in_take && (op == OP_WRITE) && (32'(entry_index) < MAX_SCREENS);
    assign wr_rect.ox = origin_x;
    assign wr_rect.oy = origin_y;
    assign wr_rect.w  = rect_width;
    assign wr_rect.h  = rect_height;

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  rd_addr = AW'(current_screen);
            S_SCAN:  rd_addr = AW'(scan_idx_reg + CW'(1));
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[AW'(entry_index)] <= wr_rect;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // shared compare unit: local test on the current screen, global test on scan
    assign lx_ext = $signed({{2{lx_reg[POS_W-1]}}, lx_reg});
    assign ly_ext = $signed({{2{ly_reg[POS_W-1]}}, ly_reg});

    always_comb
    begin
        unit_rect = rd_data_reg;
        unit_x    = $signed(gx_reg);
        unit_y    = $signed(gy_reg);
        if (state_reg == S_CUR)
        begin
            unit_rect.ox = '0;
            unit_rect.oy = '0;
            unit_x       = lx_ext;
            unit_y       = ly_ext;
        end
    end

    cshr_hit_unit u_hit (
        .pt_x   (unit_x),
        .pt_y   (unit_y),
        .rect   (unit_rect),
        .result (unit_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        gx_next        = gx_reg;
        gy_next        = gy_reg;
        res_sw_next    = res_sw_reg;
        res_scr_next   = res_scr_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                res_sw_next  = 1'b0;
                res_scr_next = current_screen;
                res_x_next   = local_x;
                res_y_next   = local_y;
                if (in_take && (op == OP_ROUTE))
                begin
                    state_next = shortcut ? S_EMIT : S_CUR;
                end
            end
            S_CUR:
            begin
                gx_next       = GPOS_W'({3'b000, rd_data_reg.ox}) + GPOS_W'(lx_ext);
                gy_next       = GPOS_W'({3'b000, rd_data_reg.oy}) + GPOS_W'(ly_ext);
                scan_idx_next = '0;
                state_next    = unit_res.hit ? S_EMIT : S_SCAN;
            end
            S_SCAN:
            begin
                if (unit_res.hit)
                begin
                    if (32'(scan_idx_reg) != 32'(cur_reg))
                    begin
                        res_sw_next  = 1'b1;
                        res_scr_next = SCR_W'(scan_idx_reg);
                        res_x_next   = unit_res.rel_x;
                        res_y_next   = unit_res.rel_y;
                    end
                    state_next = S_EMIT;
                end
                else if (scan_idx_reg == n_lim - CW'(1))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            siu_reg       <= CFG_W'(1);
            out_valid_reg <= 1'b0;
            scan_idx_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            scan_idx_reg  <= scan_idx_next;
            if (cfg_valid && cfg_ready)
            begin
                siu_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cur_reg <= current_screen;
            lx_reg  <= local_x;
            ly_reg  <= local_y;
        end
        gx_reg      <= gx_next;
        gy_reg      <= gy_next;
        res_sw_reg  <= res_sw_next;
        res_scr_reg <= res_scr_next;
        res_x_reg   <= res_x_next;
        res_y_reg   <= res_y_next;
        if ((state_reg == S_EMIT) && out_free)
        begin
            out_sw_reg  <= res_sw_reg;
            out_scr_reg <= res_scr_reg;
            out_x_reg   <= res_x_reg;
            out_y_reg   <= res_y_reg;
        end
    end

    a_route_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && (op == OP_ROUTE) |=> state_reg != S_IDLE)
        else $error("query did not start");

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result appeared outside emit");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> scan_idx_reg < n_lim)
        else $error("scan index past searched entries");

    a_switch_other: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) && res_sw_reg |-> res_scr_reg != cur_reg)
        else $error("switch to current screen");

endmodule

// File: rtl/cshr_hit_unit.sv
// ----------------------------------------------------------------------------
// cshr_hit_unit
// Shared point-in-rectangle test with position relative to the origin.
// ----------------------------------------------------------------------------
module cshr_hit_unit
    import cshr_pkg::*;
(
    input  logic signed [GPOS_W-1:0] pt_x,
    input  logic signed [GPOS_W-1:0] pt_y,
    input  rect_t                    rect,
    output hit_t                     result
);

    logic signed [GPOS_W-1:0] lo_x;
    logic signed [GPOS_W-1:0] lo_y;
    logic signed [GPOS_W-1:0] hi_x;
    logic signed [GPOS_W-1:0] hi_y;
    logic signed [GPOS_W-1:0] dx;
    logic signed [GPOS_W-1:0] dy;

    assign lo_x = $signed({3'b000, rect.ox});
    assign lo_y = $signed({3'b000, rect.oy});
    assign hi_x = $signed({3'b000, rect.ox} + {3'b000, rect.w});
    assign hi_y = $signed({3'b000, rect.oy} + {3'b000, rect.h});
    assign dx   = pt_x - lo_x;
    assign dy   = pt_y - lo_y;

    assign result.hit   = (pt_x >= lo_x) && (pt_x < hi_x) &&
                          (pt_y >= lo_y) && (pt_y < hi_y);
    assign result.rel_x = dx[POS_W-1:0];
    assign result.rel_y = dy[POS_W-1:0];

endmodule

// File: verif/cursor_screen_hit_router_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_screen_hit_router_test
// Drives screen table writes and cursor queries into the hit router while a
// scoreboard keeps its own copy of the table and screen count, predicts each
// routed position and compares every result field against it. Sender and
// receiver gaps vary by phase; the screen count is changed between phases.
// ----------------------------------------------------------------------------
module cursor_screen_hit_router_test
    import cshr_pkg::*;
();

    localparam int SCREEN_SLOTS = 16;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic                    op;
        logic [SCR_W-1:0]        entry_index;
        logic [RECT_W-1:0]       origin_x;
        logic [RECT_W-1:0]       origin_y;
        logic [RECT_W-1:0]       rect_width;
        logic [RECT_W-1:0]       rect_height;
        logic [SCR_W-1:0]        current_screen;
        logic signed [POS_W-1:0] local_x;
        logic signed [POS_W-1:0] local_y;
    } cursor_item_t;

    typedef struct {
        logic                    switched;
        logic [SCR_W-1:0]        new_screen;
        logic signed [POS_W-1:0] out_x;
        logic signed [POS_W-1:0] out_y;
    } route_result_t;

    class screen_route_tracker;
        rect_t            screen_table[SCREEN_SLOTS];
        logic [CFG_W-1:0] screen_count = 1;
        route_result_t    expected_routes[$];
        int               errors = 0;
        int               queries = 0;
        int               switches = 0;
        int               writes = 0;

        function int pending();
            return expected_routes.size();
        endfunction

        task report(string what);
            $display("[%0t] route mismatch: %s", $time, what);
            errors++;
        endtask

        function route_result_t predict_route(cursor_item_t it);
            route_result_t res;
            rect_t         cur_rect;
            rect_t         cand;
            int            lx;
            int            ly;
            int            gx;
            int            gy;
            int            limit;
            bit            found;
            res.switched   = 1'b0;
            res.new_screen = it.current_screen;
            res.out_x      = it.local_x;
            res.out_y      = it.local_y;
            if (screen_count == 1)
                return res;
            cur_rect = screen_table[it.current_screen];
            lx = it.local_x;
            ly = it.local_y;
            if (lx >= 0 && lx < int'(cur_rect.w) && ly >= 0 && ly < int'(cur_rect.h))
                return res;
            gx = int'(cur_rect.ox) + lx;
            gy = int'(cur_rect.oy) + ly;
            limit = (screen_count > SCREEN_SLOTS) ? SCREEN_SLOTS : int'(screen_count);
            found = 1'b0;
            for (int i = 0; i < limit && !found; i++)
            begin
                cand = screen_table[i];
                if (gx >= int'(cand.ox) && gx < int'(cand.ox) + int'(cand.w) &&
                    gy >= int'(cand.oy) && gy < int'(cand.oy) + int'(cand.h))
                begin
                    found = 1'b1;
                    if (i != it.current_screen)
                    begin
                        res.switched   = 1'b1;
                        res.new_screen = SCR_W'(i);
                        res.out_x      = POS_W'(gx - int'(cand.ox));
                        res.out_y      = POS_W'(gy - int'(cand.oy));
                    end
                end
            end
            return res;
        endfunction

        function void note_item(cursor_item_t it);
            route_result_t res;
            if (it.op == OP_WRITE)
            begin
                screen_table[it.entry_index].ox = it.origin_x;
                screen_table[it.entry_index].oy = it.origin_y;
                screen_table[it.entry_index].w  = it.rect_width;
                screen_table[it.entry_index].h  = it.rect_height;
                writes++;
                return;
            end
            res = predict_route(it);
            expected_routes.push_back(res);
            queries++;
            if (res.switched)
                switches++;
        endfunction

        task check_result(route_result_t got);
            route_result_t want;
            if (expected_routes.size() == 0)
            begin
                report($sformatf("result %0b/%0d/%0d/%0d with no query pending",
                                 got.switched, got.new_screen, got.out_x, got.out_y));
                return;
            end
            want = expected_routes.pop_front();
            if (got.switched !== want.switched)
                report($sformatf("switched %b, want %b", got.switched, want.switched));
            if (got.new_screen !== want.new_screen)
                report($sformatf("new_screen %0d, want %0d", got.new_screen,
                                 want.new_screen));
            if (got.out_x !== want.out_x)
                report($sformatf("out_x %0d, want %0d", got.out_x, want.out_x));
            if (got.out_y !== want.out_y)
                report($sformatf("out_y %0d, want %0d", got.out_y, want.out_y));
        endtask
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic                    op;
    logic [SCR_W-1:0]        entry_index;
    logic [RECT_W-1:0]       origin_x;
    logic [RECT_W-1:0]       origin_y;
    logic [RECT_W-1:0]       rect_width;
    logic [RECT_W-1:0]       rect_height;
    logic [SCR_W-1:0]        current_screen;
    logic signed [POS_W-1:0] local_x;
    logic signed [POS_W-1:0] local_y;
    logic                    out_valid;
    logic                    out_stall;
    logic                    switched;
    logic [SCR_W-1:0]        new_screen;
    logic signed [POS_W-1:0] out_x;
    logic signed [POS_W-1:0] out_y;

    int src_idle = 0;
    int dst_idle = 0;
    int src_plan[3] = '{9, 76, 0};
    int dst_plan[3] = '{76, 9, 0};
    int count_plan[15] = '{16, 2, 31, 1, 9, 0, 16, 5, 17, 12, 3, 16, 31, 7, 16};
    int settings_used = 0;

    screen_route_tracker routes;

    cursor_screen_hit_router #(
        .MAX_SCREENS(SCREEN_SLOTS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .entry_index(entry_index),
        .origin_x(origin_x),
        .origin_y(origin_y),
        .rect_width(rect_width),
        .rect_height(rect_height),
        .current_screen(current_screen),
        .local_x(local_x),
        .local_y(local_y),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .switched(switched),
        .new_screen(new_screen),
        .out_x(out_x),
        .out_y(out_y)
    );

    always #2 clk = ~clk;

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < dst_idle);

    always @(posedge clk)
    begin : take_result
        route_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.switched   = switched;
            got.new_screen = new_screen;
            got.out_x      = out_x;
            got.out_y      = out_y;
            routes.check_result(got);
        end
    end

    function automatic cursor_item_t make_write(int idx, int ox, int oy, int w, int h);
        cursor_item_t it;
        it.op             = OP_WRITE;
        it.entry_index    = SCR_W'(idx);
        it.origin_x       = RECT_W'(ox);
        it.origin_y       = RECT_W'(oy);
        it.rect_width     = RECT_W'(w);
        it.rect_height    = RECT_W'(h);
        it.current_screen = SCR_W'($urandom);
        it.local_x        = POS_W'($urandom);
        it.local_y        = POS_W'($urandom);
        return it;
    endfunction

    function automatic cursor_item_t make_query(int cur, int lx, int ly);
        cursor_item_t it;
        it.op             = OP_ROUTE;
        it.entry_index    = SCR_W'($urandom);
        it.origin_x       = RECT_W'($urandom);
        it.origin_y       = RECT_W'($urandom);
        it.rect_width     = RECT_W'($urandom);
        it.rect_height    = RECT_W'($urandom);
        it.current_screen = SCR_W'(cur);
        it.local_x        = POS_W'(lx);
        it.local_y        = POS_W'(ly);
        return it;
    endfunction

    // pick a coordinate just outside or inside a span of the given size
    function automatic int near_span(int size);
        case ($urandom_range(3))
            0: return -1 - int'($urandom_range(255));
            1: return size + int'($urandom_range(255));
            default: return (size == 0) ? 0 : int'($urandom_range(size - 1));
        endcase
    endfunction

    function automatic cursor_item_t pick_query();
        int    cur;
        int    roll;
        rect_t r;
        cur  = $urandom_range(SCREEN_SLOTS - 1);
        r    = routes.screen_table[cur];
        roll = $urandom_range(99);
        if (roll < 60)
            return make_query(cur, near_span(r.w), near_span(r.h));
        else if (roll < 80)
            return make_query(cur, int'($urandom), int'($urandom));
        else
            return make_query(cur, (r.w == 0) ? 0 : int'($urandom_range(r.w - 1)),
                              (r.h == 0) ? 0 : int'($urandom_range(r.h - 1)));
    endfunction

    task automatic send_item(cursor_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < src_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        op             <= it.op;
        entry_index    <= it.entry_index;
        origin_x       <= it.origin_x;
        origin_y       <= it.origin_y;
        rect_width     <= it.rect_width;
        rect_height    <= it.rect_height;
        current_screen <= it.current_screen;
        local_x        <= it.local_x;
        local_y        <= it.local_y;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        routes.note_item(it);
    endtask

    // hold input until every pending route has come back, then let the block settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (routes.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_screens(int count);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= CFG_W'(count);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        routes.screen_count = CFG_W'(count);
        settings_used++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // tile all sixteen entries as a 4x4 wall of adjacent screens
    task automatic load_grid();
        int col_x[4];
        int col_w[4];
        int row_y[4];
        int row_h[4];
        int span;
        span = ($urandom_range(3) == 0) ? 8 : 3000;
        col_x[0] = $urandom_range(20000);
        row_y[0] = $urandom_range(20000);
        for (int k = 0; k < 4; k++)
        begin
            col_w[k] = $urandom_range(1, span);
            row_h[k] = $urandom_range(1, span);
            if (k > 0)
            begin
                col_x[k] = col_x[k - 1] + col_w[k - 1];
                row_y[k] = row_y[k - 1] + row_h[k - 1];
            end
        end
        for (int i = 0; i < SCREEN_SLOTS; i++)
            send_item(make_write(i, col_x[i % 4], row_y[i / 4], col_w[i % 4], row_h[i / 4]));
    endtask

    initial
    begin
        #4000000;
        $display("cursor_screen_hit_router test failed");
        $finish;
    end

    initial
    begin
        int ox;
        int oy;
        int w;
        int h;
        int roll;
        routes         = new();
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        out_stall      = 1'b0;
        op             = OP_WRITE;
        entry_index    = '0;
        origin_x       = '0;
        origin_y       = '0;
        rect_width     = '0;
        rect_height    = '0;
        current_screen = '0;
        local_x        = '0;
        local_y        = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_screens(SCREEN_SLOTS);
        for (int i = 0; i < SCREEN_SLOTS; i++)
        begin
            ox = (i % 4) * 1000;
            oy = (i / 4) * 800;
            w  = 1000;
            h  = 800;
            case (i)
                12: begin ox = 32767; oy = 32767; w = 32767; h = 32767; end
                13: begin ox = 500;   oy = 400;   w = 1;     h = 1;     end
                14: h = 0;
                15: w = 0;
                default: ;
            endcase
            send_item(make_write(i, ox, oy, w, h));
        end
        send_item(make_query(0, 10, 10));
        send_item(make_query(0, 1000, 5));
        send_item(make_query(1, -1, 0));
        send_item(make_query(0, -1, 0));
        send_item(make_query(5, 0, 800));
        send_item(make_query(0, -32768, 32767));
        send_item(make_query(3, 32767, -32768));
        send_item(make_query(12, -1, -1));
        send_item(make_query(13, 1, 0));
        send_item(make_query(14, 0, 0));
        send_item(make_query(15, -1, -1));
        drain();
        write_screens(1);
        send_item(make_query(0, 1000, 5));
        drain();
        write_screens(0);
        send_item(make_query(0, 1000, 5));
        drain();
        write_screens(31);
        send_item(make_query(0, 1000, 5));

        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle = src_plan[ph];
            dst_idle = dst_plan[ph];
            for (int seg = 0; seg < 5; seg++)
            begin
                drain();
                write_screens(count_plan[ph * 5 + seg]);
                load_grid();
                for (int k = 0; k < 84; k++)
                begin
                    roll = $urandom_range(99);
                    if (roll < 2)
                        drain();
                    else if (roll < 8)
                        send_item(make_write($urandom_range(SCREEN_SLOTS - 1),
                                             $urandom_range(32767), $urandom_range(32767),
                                             ($urandom_range(49) == 0) ? 0 :
                                                 $urandom_range(1, 32767),
                                             ($urandom_range(49) == 0) ? 0 :
                                                 $urandom_range(1, 32767)));
                    else
                        send_item(pick_query());
                end
            end
        end

        src_idle = 0;
        dst_idle = 0;
        drain();
        $display("routed %0d cursor queries, %0d of them onto another screen,",
                 routes.queries, routes.switches);
        $display("with %0d table writes across %0d screen count settings",
                 routes.writes, settings_used);
        if (routes.errors == 0)
            $display("cursor_screen_hit_router test passed");
        else
            $display("cursor_screen_hit_router test failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/cshr_pkg.sv
rtl/cshr_hit_unit.sv
rtl/cursor_screen_hit_router.sv
verif/cursor_screen_hit_router_test.sv
